### design/range_max_segment_tree_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the range maximum segment tree
// Checks are compiled out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RANGE_MAX_SEGMENT_TREE_TOP_ASSERT_SVH
`define RANGE_MAX_SEGMENT_TREE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RMST_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rmst assertion failed");
// next-cycle implication
`define RMST_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rmst assertion failed");
`else
`define RMST_ASSERT_IMP(lbl, ante, cons)
`define RMST_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### design/rmst_pkg.sv
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rmst_pkg;

	// request opcodes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// register index (paddr[2])
	localparam logic REG_SIZE_IN_USE = 1'b0;

	typedef struct packed {
		logic clear_start;
		logic clear_step;
		logic load_start;
		logic load_step;
		logic query_start;
		logic query_step;
		logic out_load;
	} ctl_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic load_hit;
		logic load_last;
		logic query_more;
		logic out_free;
	} dp_stat_t;

endpackage

### design/range_max_segment_tree_top.sv
// Load: one RAM write per tree level, from the leaf up to the root.
// Ignored load (index outside size in use): accepted without a RAM write.
// Query: bottom-up walk of the two-port node RAM, a merge drain, then the output register.
// One request at a time; a finished result waits in its output register.
// Reset and every size write start a clear pass over all 2*MAX_ELEMENTS nodes, in_ready low.
// Size resets to MAX_ELEMENTS; all tree nodes read as empty after the pass.
// ----------------------------------------------------------------------------
// range_max_segment_tree_top
// Range maximum segment tree with APB size register and valid/ready channels.
// ----------------------------------------------------------------------------
`include "range_max_segment_tree_top_assert.svh"

module range_max_segment_tree_top #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int VALUE_WIDTH  = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [2:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  cmd,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]       elem_index,
	input  logic signed [VALUE_WIDTH-1:0]         elem_value,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]       range_low,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]       range_high,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [VALUE_WIDTH-1:0]         max_value,
	output logic                                  range_empty
);

	localparam int SIZE_W = $clog2(MAX_ELEMENTS + 1);

	rmst_pkg::ctl_cmd_t ctl;
	rmst_pkg::dp_stat_t stat;

	logic [SIZE_W-1:0] size_q;
	logic [SIZE_W-1:0] size_wr;
	logic              reg_hit;
	logic              cfg_wr;

	assign pready = 1'b1;

	always_comb begin
		reg_hit = 1'b0;
		prdata  = '0;
		unique case (paddr[2])
			rmst_pkg::REG_SIZE_IN_USE: begin
				reg_hit = 1'b1;
				prdata  = 32'(size_q);
			end
			default: ;
		endcase
	end

	assign cfg_wr = psel & penable & pwrite & pready & reg_hit;

	// clamp to 1..MAX_ELEMENTS
	assign size_wr = (pwdata[SIZE_W-1:0] == '0) ? SIZE_W'(1) :
		(pwdata[SIZE_W-1:0] > SIZE_W'(MAX_ELEMENTS)) ? SIZE_W'(MAX_ELEMENTS) :
		pwdata[SIZE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_W'(MAX_ELEMENTS);
		end else if (cfg_wr) begin
			size_q <= size_wr;
		end
	end

	rmst_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.cmd     (cmd),
		.cfg_wr  (cfg_wr),
		.stat    (stat),
		.in_ready(in_ready),
		.ctl     (ctl)
	);

	rmst_dp #(
		.MAX_ELEMENTS(MAX_ELEMENTS),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (ctl),
		.stat       (stat),
		.size_in_use(size_q),
		.elem_index (elem_index),
		.elem_value (elem_value),
		.range_low  (range_low),
		.range_high (range_high),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.max_value  (max_value),
		.range_empty(range_empty)
	);

	`RMST_ASSERT_IMP(a_no_request_in_clear, ctl.clear_step, !in_ready)
	`RMST_ASSERT_NXT(a_size_write_clears, cfg_wr, ctl.clear_step || ctl.clear_start)
	`RMST_ASSERT_IMP(a_result_slot_free, ctl.out_load, !out_valid || out_ready)

endmodule

### design/rmst_ram.sv
// ----------------------------------------------------------------------------
// rmst_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rmst_ram #(
	parameter int WIDTH = 49,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_a_q;
	logic [WIDTH-1:0] rd_b_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_a_q <= mem_q[rd_addr_a];
		rd_b_q <= mem_q[rd_addr_b];
	end

	assign rd_data_a = rd_a_q;
	assign rd_data_b = rd_b_q;

endmodule

### design/rmst_ctrl.sv
// ----------------------------------------------------------------------------
// rmst_ctrl
// Sequencer: clear pass, leaf-to-root load walk, bottom-up query walk.
// ----------------------------------------------------------------------------
module rmst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                cmd,
	input  logic                cfg_wr,
	input  rmst_pkg::dp_stat_t  stat,
	output logic                in_ready,
	output rmst_pkg::ctl_cmd_t  ctl
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOAD,
		ST_QWALK,
		ST_QDRAIN,
		ST_QOUT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE) & ~cfg_wr;

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				ctl.clear_step = 1'b1;
				if (stat.clear_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					if (cmd == rmst_pkg::CMD_QUERY) begin
						ctl.query_start = 1'b1;
						state_d         = ST_QWALK;
					end else if (stat.load_hit) begin
						ctl.load_start = 1'b1;
						state_d        = ST_LOAD;
					end
				end
			end
			ST_LOAD: begin
				ctl.load_step = 1'b1;
				if (stat.load_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_QWALK: begin
				ctl.query_step = 1'b1;
				if (!stat.query_more) begin
					state_d = ST_QDRAIN;
				end
			end
			// merge pipeline still has to settle before the result is taken
			ST_QDRAIN: state_d = ST_QOUT;
			ST_QOUT: begin
				if (stat.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
		// size write wipes the tree
		if (cfg_wr) begin
			ctl             = '0;
			ctl.clear_start = 1'b1;
			state_d         = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### design/rmst_dp.sv
// ----------------------------------------------------------------------------
// rmst_dp
// Tree node RAM, address walkers, max merge pipeline and result register.
// ----------------------------------------------------------------------------
module rmst_dp #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int VALUE_WIDTH  = 48
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rmst_pkg::ctl_cmd_t                    ctl,
	output rmst_pkg::dp_stat_t                    stat,
	input  logic [$clog2(MAX_ELEMENTS+1)-1:0]     size_in_use,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]       elem_index,
	input  logic signed [VALUE_WIDTH-1:0]         elem_value,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]       range_low,
	input  logic [$clog2(MAX_ELEMENTS)-1:0]       range_high,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic signed [VALUE_WIDTH-1:0]         max_value,
	output logic                                  range_empty
);

	localparam int SIZE_W = $clog2(MAX_ELEMENTS + 1);
	localparam int DEPTH  = 2 * MAX_ELEMENTS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int PTR_W  = ADDR_W + 1;
	localparam int NODE_W = VALUE_WIDTH + 1;

	// node = {valid, value}; invalid stands for the empty sentinel
	function automatic logic [NODE_W-1:0] node_max(input logic [NODE_W-1:0] a,
			input logic [NODE_W-1:0] b);
		logic a_wins;
		a_wins = a[NODE_W-1] & (~b[NODE_W-1] |
			($signed(a[VALUE_WIDTH-1:0]) > $signed(b[VALUE_WIDTH-1:0])));
		node_max = a_wins ? a : (b[NODE_W-1] ? b : a);
	endfunction

	logic [ADDR_W-1:0] clr_q;
	logic [ADDR_W-1:0] p_q;
	logic [NODE_W-1:0] lacc_q;
	logic [PTR_W-1:0]  l_q;
	logic [PTR_W-1:0]  r_q;
	logic              use_a_s1;
	logic              use_b_s1;
	logic [NODE_W-1:0] pair_s2;
	logic [NODE_W-1:0] qacc_q;
	logic              out_valid_q;
	logic [VALUE_WIDTH-1:0] max_q;
	logic              empty_q;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [NODE_W-1:0] wr_data;
	logic [ADDR_W-1:0] rd_addr_a;
	logic [ADDR_W-1:0] rd_addr_b;
	logic [NODE_W-1:0] rd_data_a;
	logic [NODE_W-1:0] rd_data_b;

	logic [ADDR_W-1:0] leaf;
	logic [ADDR_W-1:0] parent;
	logic [NODE_W-1:0] lmerge;
	logic [SIZE_W-1:0] size_m1;
	logic [SIZE_W-1:0] lo_ext;
	logic [SIZE_W-1:0] hi_ext;
	logic [SIZE_W-1:0] hi_clip;
	logic              q_nonempty;
	logic [PTR_W-1:0]  l_start;
	logic [PTR_W-1:0]  r_start;
	logic [PTR_W-1:0]  r_dec;
	logic              q_act;

	rmst_ram #(
		.WIDTH(NODE_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk      (clk),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.rd_addr_a(rd_addr_a),
		.rd_addr_b(rd_addr_b),
		.rd_data_a(rd_data_a),
		.rd_data_b(rd_data_b)
	);

	// load walk
	assign leaf   = ADDR_W'(PTR_W'(elem_index) + PTR_W'(MAX_ELEMENTS));
	assign parent = p_q >> 1;
	assign lmerge = node_max(lacc_q, rd_data_a);

	// query range, clipped to the size in use
	assign size_m1    = size_in_use - SIZE_W'(1);
	assign lo_ext     = SIZE_W'(range_low);
	assign hi_ext     = SIZE_W'(range_high);
	assign hi_clip    = (hi_ext > size_m1) ? size_m1 : hi_ext;
	assign q_nonempty = (lo_ext <= hi_clip);
	assign l_start    = PTR_W'(lo_ext) + PTR_W'(MAX_ELEMENTS);
	assign r_start    = PTR_W'(hi_clip) + PTR_W'(MAX_ELEMENTS) + PTR_W'(1);
	assign r_dec      = r_q - PTR_W'(1);
	assign q_act      = ctl.query_step & (l_q < r_q);

	always_comb begin
		wr_en   = ctl.clear_step | ctl.load_start | ctl.load_step;
		wr_addr = clr_q;
		wr_data = '0;
		if (ctl.load_start) begin
			wr_addr = leaf;
			wr_data = {1'b1, elem_value};
		end else if (ctl.load_step) begin
			wr_addr = parent;
			wr_data = lmerge;
		end
	end

	// port a: sibling during loads, left edge during queries
	always_comb begin
		rd_addr_a = l_q[ADDR_W-1:0];
		if (ctl.load_start) begin
			rd_addr_a = {leaf[ADDR_W-1:1], ~leaf[0]};
		end else if (ctl.load_step) begin
			rd_addr_a = {parent[ADDR_W-1:1], ~parent[0]};
		end
	end
	assign rd_addr_b = r_dec[ADDR_W-1:0];

	assign stat.clear_last = (clr_q == ADDR_W'(DEPTH - 1));
	assign stat.load_hit   = (SIZE_W'(elem_index) < size_in_use);
	assign stat.load_last  = (parent == ADDR_W'(1));
	assign stat.query_more = (l_q < r_q);
	assign stat.out_free   = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			use_a_s1    <= 1'b0;
			use_b_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl.clear_start) begin
				clr_q <= '0;
			end else if (ctl.clear_step) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			use_a_s1 <= q_act & l_q[0];
			use_b_s1 <= q_act & r_q[0];
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_start) begin
			p_q    <= leaf;
			lacc_q <= {1'b1, elem_value};
		end else if (ctl.load_step) begin
			p_q    <= parent;
			lacc_q <= lmerge;
		end

		if (ctl.query_start) begin
			l_q <= q_nonempty ? l_start : '0;
			r_q <= q_nonempty ? r_start : '0;
		end else if (q_act) begin
			l_q <= (l_q + PTR_W'(l_q[0])) >> 1;
			r_q <= r_q >> 1;
		end

		pair_s2 <= node_max(use_a_s1 ? rd_data_a : '0, use_b_s1 ? rd_data_b : '0);

		if (ctl.query_start) begin
			qacc_q <= '0;
		end else begin
			qacc_q <= node_max(qacc_q, pair_s2);
		end

		if (ctl.out_load) begin
			max_q   <= qacc_q[NODE_W-1] ? qacc_q[VALUE_WIDTH-1:0] : '0;
			empty_q <= ~qacc_q[NODE_W-1];
		end
	end

	assign out_valid   = out_valid_q;
	assign max_value   = max_q;
	assign range_empty = empty_q;

endmodule
